// ----- hdl/p2u_pkg.sv -----
// Shared types, constants and character mapping functions for the transcoder.
package p2u_pkg;

   localparam logic [1:0] ENC_BYTE = 2'd0;
   localparam logic [1:0] ENC_U16LE = 2'd1;
   localparam logic [1:0] ENC_U16BE = 2'd2;
   localparam logic [1:0] ENC_UTF8 = 2'd3;

   localparam logic [1:0] SET_ASCII = 2'd0;
   localparam logic [1:0] SET_LATIN1 = 2'd1;
   localparam logic [1:0] SET_UNICODE = 2'd2;
   localparam logic [1:0] SET_WIN1252 = 2'd3;

   localparam logic [2:0] REG_ENCODING = 3'd0;
   localparam logic [2:0] REG_TARGET = 3'd1;
   localparam logic [2:0] REG_FONT = 3'd2;
   localparam logic [2:0] REG_NEWLINE = 3'd3;
   localparam logic [2:0] REG_KEEP = 3'd4;
   localparam logic [2:0] REG_BOM = 3'd5;

   localparam logic [1:0] NL_CR = 2'd0;
   localparam logic [1:0] NL_LF = 2'd1;
   localparam logic [1:0] NL_LFCR = 2'd2;
   localparam logic [1:0] NL_CRLF = 2'd3;

   localparam int unsigned MAX_BYTES = 6;

   // Configuration as seen by the pipeline
   typedef struct packed {
      logic [1:0] encoding;
      logic [1:0] target;
      logic       font;
      logic [1:0] newline;
      logic [2:0] keep;
      logic       bom;
   } cfg_type;

   // Byte sequence for one item, built by the front part
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      count;
   } seq_type;

   function automatic logic [15:0] shared_gfx(input logic [4:0] i);
      logic [15:0] r;
      begin
         case (i)
            5'd0: r = 16'h00a0; 5'd1: r = 16'h258c; 5'd2: r = 16'h2584;
            5'd3: r = 16'h2594; 5'd4: r = 16'h2581; 5'd5: r = 16'h258f;
            5'd6: r = 16'h25a9; 5'd7: r = 16'h2595; 5'd8: r = 16'he0a8;
            5'd9: r = 16'he1a9; 5'd10: r = 16'he0aa; 5'd11: r = 16'h251c;
            5'd12: r = 16'h2597; 5'd13: r = 16'h2514; 5'd14: r = 16'h2510;
            5'd15: r = 16'h2582; 5'd16: r = 16'h250c; 5'd17: r = 16'h2534;
            5'd18: r = 16'h253c; 5'd19: r = 16'h2524; 5'd20: r = 16'h258e;
            5'd21: r = 16'h258d; 5'd22: r = 16'he0b6; 5'd23: r = 16'he0b7;
            5'd24: r = 16'he0b8; 5'd25: r = 16'h2583; 5'd26: r = 16'h2713;
            5'd27: r = 16'h2596; 5'd28: r = 16'h259d; 5'd29: r = 16'h2518;
            5'd30: r = 16'h2598; default: r = 16'h259a;
         endcase
         return r;
      end
   endfunction

   function automatic logic [15:0] upper_gfx(input logic [4:0] i);
      logic [15:0] r;
      begin
         case (i)
            5'd0: r = 16'h2500; 5'd1: r = 16'h2660; 5'd2: r = 16'he0c2;
            5'd3: r = 16'he0c3; 5'd4: r = 16'he0c4; 5'd5: r = 16'he0c5;
            5'd6: r = 16'he0c6; 5'd7: r = 16'he0c7; 5'd8: r = 16'he0c8;
            5'd9: r = 16'h256e; 5'd10: r = 16'h2570; 5'd11: r = 16'h256f;
            5'd12: r = 16'h2599; 5'd13: r = 16'h2572; 5'd14: r = 16'h2571;
            5'd15: r = 16'h259b; 5'd16: r = 16'h259c; 5'd17: r = 16'h2219;
            5'd18: r = 16'he0d2; 5'd19: r = 16'h2665; 5'd20: r = 16'he0d4;
            5'd21: r = 16'h256d; 5'd22: r = 16'h2573; 5'd23: r = 16'h2218;
            5'd24: r = 16'h2663; 5'd25: r = 16'he0d9; 5'd26: r = 16'h2666;
            5'd27: r = 16'h253c; 5'd28: r = 16'he0dc; 5'd29: r = 16'h2502;
            5'd30: r = 16'h03c0; default: r = 16'h25e5;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- hdl/petscii_to_unicode_transcoder_top.sv -----
// An item's first byte passes through the front stage register, the queue and the output
// register before it is valid. Throughput: one output byte per cycle while the receiver does
// not stall; a multi-byte item holds the output until its bytes are taken, so single-byte
// items flow at one per cycle. A two-entry queue lets input continue while bytes drain.
// Reset (synchronous, active high) empties all stages and loads register defaults.
module petscii_to_unicode_transcoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_petscii_byte,
   input  logic       req_text_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import p2u_pkg::*;

   cfg_type cfg_ff;
   logic    fq_valid, fq_stall, qb_valid, qb_take;
   seq_type fq_seq, qb_seq;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{encoding: ENC_BYTE, target: SET_ASCII, font: 1'b0,
                     newline: NL_CRLF, keep: 3'd0, bom: 1'b0};
      end else if (csr_valid) begin
         case (csr_index)
            REG_ENCODING: cfg_ff.encoding <= csr_data[1:0];
            REG_TARGET: cfg_ff.target <= csr_data[1:0];
            REG_FONT: cfg_ff.font <= csr_data[0];
            REG_NEWLINE: cfg_ff.newline <= csr_data[1:0];
            REG_KEEP: cfg_ff.keep <= csr_data[2:0];
            REG_BOM: cfg_ff.bom <= csr_data[0];
            default: ;
         endcase
      end
   end

   p2u_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_valid), .in_stall(req_stall),
      .in_byte(req_petscii_byte), .in_start(req_text_start),
      .q_valid(fq_valid), .q_stall(fq_stall), .q_seq(fq_seq)
   );

   p2u_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_seq(fq_seq),
      .rd_valid(qb_valid), .rd_take(qb_take), .rd_seq(qb_seq)
   );

   p2u_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(qb_valid), .q_take(qb_take), .q_seq(qb_seq),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_byte(rsp_out_byte), .out_last(rsp_last_of_run)
   );

endmodule

// ----- hdl/p2u_front.sv -----
// Front part: map a character to a code point, clip it and build its byte sequence.
module p2u_front (
   input  logic             clock,
   input  logic             reset,
   input  p2u_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [7:0]       in_byte,
   input  logic             in_start,
   output logic             q_valid,
   input  logic             q_stall,
   output p2u_pkg::seq_type q_seq
);
   import p2u_pkg::*;

   logic        valid_ff, valid_in;
   seq_type     seq_ff, seq_in;
   logic [15:0] cp, clip;
   logic        lower, isowin;
   logic [7:0]  c;

   // Map the character to a code point
   always_comb begin
      lower = ~cfg.font;
      isowin = (cfg.target == SET_LATIN1) || (cfg.target == SET_WIN1252);
      c = in_byte;
      cp = {8'd0, in_byte};
      if (in_byte < 8'h41) begin
         cp = {8'd0, in_byte};
      end else if (in_byte < 8'h5b) begin
         cp = {8'd0, lower ? (in_byte ^ 8'h20) : in_byte};
      end else if (in_byte < 8'h60) begin
         if (in_byte == 8'h5c && !cfg.keep[0]) cp = 16'h00a3;
         else if (in_byte == 8'h5e && !cfg.keep[1]) cp = 16'h2190;
      end else if (in_byte == 8'hff) begin
         if (cfg.keep[2]) cp = 16'h00ff;
         else cp = lower ? 16'he1ff : 16'h03c0;
      end else begin
         if (in_byte < 8'h80) c = in_byte ^ 8'ha0;
         else if (in_byte >= 8'he0) c = in_byte ^ 8'h40;
         if (c < 8'ha0) begin
            cp = ((cfg.target == SET_ASCII) || (cfg.target == SET_WIN1252)) ?
                 16'h0006 : {8'd0, c};
         end else if (c < 8'hc0) begin
            cp = shared_gfx(c[4:0]);
            if (isowin) begin
               if (c == 8'ha3) cp = 16'h00af;
               else if (c == 8'ha4) cp = 16'h005f;
               else if (c == 8'hab) cp = 16'h007d;
               else if (c == 8'hb3) cp = 16'h007b;
            end
            if (!lower) begin
               if (c == 8'ha9) cp = 16'h25e4;
               else if (c == 8'hba) cp = 16'h259f;
            end
         end else if (!lower) begin
            cp = upper_gfx(c[4:0]);
         end else if (c == 8'hc0) cp = 16'h2500;
         else if (c < 8'hdb) cp = {8'd0, c ^ 8'h80};
         else if (c == 8'hdb) cp = 16'h253c;
         else if (c == 8'hdc) cp = 16'he0dc;
         else if (c == 8'hdd) cp = isowin ? 16'h007c : 16'h2502;
         else if (c == 8'hde) cp = 16'he1de;
         else cp = 16'h25a7;
      end
   end

   // Clip to the target set
   always_comb begin
      clip = cp;
      unique case (cfg.target)
         SET_ASCII: if (cp > 16'h007f) clip = 16'h007f;
         SET_LATIN1: if (cp > 16'h00ff) clip = 16'h007f;
         SET_WIN1252: begin
            if (cp == 16'h2022 || cp == 16'h2219) clip = 16'h0095;
            else if (cp > 16'h00ff || (cp >= 16'h0080 && cp < 16'h00a0))
               clip = 16'h007f;
         end
         default: clip = cp;
      endcase
   end

   // Assemble the byte sequence: order mark, then units
   always_comb begin
      logic [2:0]  n;
      logic [15:0] u0, u1;
      logic        two;
      n = 3'd0;
      seq_in.bytes = '0;
      two = 1'b0;
      u0 = clip;
      u1 = 16'h000a;
      if (in_start && cfg.bom && cfg.encoding == ENC_U16LE) begin
         seq_in.bytes[0] = 8'hff; seq_in.bytes[1] = 8'hfe; n = 3'd2;
      end else if (in_start && cfg.bom && cfg.encoding == ENC_U16BE) begin
         seq_in.bytes[0] = 8'hfe; seq_in.bytes[1] = 8'hff; n = 3'd2;
      end
      if (in_byte == 8'h0d) begin
         unique case (cfg.newline)
            NL_CR: u0 = 16'h000d;
            NL_LF: u0 = 16'h000a;
            NL_LFCR: begin u0 = 16'h000a; u1 = 16'h000d; two = 1'b1; end
            default: begin u0 = 16'h000d; u1 = 16'h000a; two = 1'b1; end
         endcase
      end
      for (int k = 0; k < 2; k++) begin
         logic [15:0] u;
         u = (k == 0) ? u0 : u1;
         if (k == 0 || two) begin
            unique case (cfg.encoding)
               ENC_BYTE: begin
                  seq_in.bytes[n] = (u > 16'h00ff) ? 8'h7f : u[7:0]; n = n + 3'd1;
               end
               ENC_U16LE: begin
                  seq_in.bytes[n] = u[7:0]; seq_in.bytes[n + 3'd1] = u[15:8];
                  n = n + 3'd2;
               end
               ENC_U16BE: begin
                  seq_in.bytes[n] = u[15:8]; seq_in.bytes[n + 3'd1] = u[7:0];
                  n = n + 3'd2;
               end
               default: begin
                  if (u < 16'h0080) begin
                     seq_in.bytes[n] = u[7:0]; n = n + 3'd1;
                  end else if (u < 16'h0800) begin
                     seq_in.bytes[n] = {3'b110, u[10:6]};
                     seq_in.bytes[n + 3'd1] = {2'b10, u[5:0]};
                     n = n + 3'd2;
                  end else begin
                     seq_in.bytes[n] = {4'b1110, u[15:12]};
                     seq_in.bytes[n + 3'd1] = {2'b10, u[11:6]};
                     seq_in.bytes[n + 3'd2] = {2'b10, u[5:0]};
                     n = n + 3'd3;
                  end
               end
            endcase
         end
      end
      seq_in.count = n;
   end

   // Stage register: advance when empty or when the queue takes it
   assign in_stall = valid_ff && q_stall;
   assign valid_in = in_valid || in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         seq_ff <= seq_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_seq = seq_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (seq_ff.count >= 3'd1 && seq_ff.count <= 3'd6))
      else $error("sequence length out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      $past(in_stall) && !$past(reset) |-> $stable(seq_ff))
      else $error("stalled stage changed");
   a_keep: assert property (@(posedge clock) disable iff (reset)
      $past(valid_ff && q_stall) && !$past(reset) |-> valid_ff)
      else $error("stalled item lost");
`endif
endmodule

// ----- hdl/p2u_queue.sv -----
// Two-entry queue between the front and back parts.
module p2u_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_stall,
   input  p2u_pkg::seq_type wr_seq,
   output logic             rd_valid,
   input  logic             rd_take,
   output p2u_pkg::seq_type rd_seq
);
   import p2u_pkg::*;

   seq_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign wr_stall = (fill_ff == 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_seq = mem_ff[rptr_ff];
   assign push = wr_valid && !wr_stall;
   assign pop = rd_take && rd_valid;

   // Advance pointers and fill level
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_seq;
      end
   end

`ifndef ASSERT_OFF
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2) else $error("queue overfilled");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0 || fill_ff == 2'd2) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree with fill");
   a_odd: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd1) |-> (wptr_ff != rptr_ff))
      else $error("queue pointers disagree with fill");
`endif
endmodule

// ----- hdl/p2u_back.sv -----
// Back part: emit the queued byte sequence one byte per cycle while the output does not stall.
module p2u_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_take,
   input  p2u_pkg::seq_type q_seq,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [7:0]       out_byte,
   output logic             out_last
);
   import p2u_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [2:0] idx_ff, idx_in;
   logic       load, is_last;

   // Load a new byte when the output register is free
   assign load = !(valid_ff && out_stall) && q_valid;
   assign is_last = (idx_ff + 3'd1 == q_seq.count);
   assign q_take = load && is_last;
   assign valid_in = load || (valid_ff && out_stall);
   assign idx_in = load ? (is_last ? 3'd0 : idx_ff + 3'd1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= q_seq.bytes[idx_ff];
         last_ff <= is_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte = byte_ff;
   assign out_last = last_ff;

`ifndef ASSERT_OFF
   a_idx: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 3'd6) else $error("byte index out of range");
   a_idx_q: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 3'd0) |-> q_valid) else $error("sequence left queue mid-run");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |=> (idx_ff == 3'd0)) else $error("index not rewound");
`endif
endmodule

// ----- sim/tb_petscii_to_unicode_transcoder_top.sv -----
// Self-checking testbench for the PETSCII transcoder: predicts output bytes per item.
module tb_petscii_to_unicode_transcoder_top;
   import p2u_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_petscii_byte;
   logic       req_text_start;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   typedef struct {
      logic [7:0] byte_val;
      logic       last;
   } out_item_t;

   out_item_t  expected_bytes[$];
   int         error_count;
   int         items_sent;
   int         bytes_seen;
   bit         hold_off;
   bit         wrap_up;
   cfg_type    shadow;

   petscii_to_unicode_transcoder_top dut (.*);

   // Clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Report one mismatch and count it
   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Map a PETSCII code to a code point under the shadow configuration
   function automatic logic [15:0] map_code_point(input logic [7:0] code);
      logic       lower_font;
      logic       iso_or_win;
      logic [7:0] c;
      logic [15:0] cp;
      lower_font = (shadow.font == 1'b0);
      iso_or_win = (shadow.target == SET_LATIN1 || shadow.target == SET_WIN1252);
      c = code;
      if (c < 8'h41) return {8'h00, c};
      if (c < 8'h5b) return lower_font ? {8'h00, c ^ 8'h20} : {8'h00, c};
      if (c < 8'h60) begin
         if (c == 8'h5c && !shadow.keep[0]) return 16'h00a3;
         if (c == 8'h5e && !shadow.keep[1]) return 16'h2190;
         return {8'h00, c};
      end
      if (c < 8'h80) begin
         c = c ^ 8'ha0;
      end else if (c == 8'hff) begin
         if (shadow.keep[2]) return 16'h00ff;
         return lower_font ? 16'he1ff : 16'h03c0;
      end else if (c >= 8'he0) begin
         c = c ^ 8'h40;
      end
      if (c < 8'ha0)
         return (shadow.target == SET_ASCII || shadow.target == SET_WIN1252) ?
                16'h0006 : {8'h00, c};
      if (c < 8'hc0) begin
         case (c[4:0])
            5'd0: cp = 16'h00a0; 5'd1: cp = 16'h258c; 5'd2: cp = 16'h2584;
            5'd3: cp = 16'h2594; 5'd4: cp = 16'h2581; 5'd5: cp = 16'h258f;
            5'd6: cp = 16'h25a9; 5'd7: cp = 16'h2595; 5'd8: cp = 16'he0a8;
            5'd9: cp = 16'he1a9; 5'd10: cp = 16'he0aa; 5'd11: cp = 16'h251c;
            5'd12: cp = 16'h2597; 5'd13: cp = 16'h2514; 5'd14: cp = 16'h2510;
            5'd15: cp = 16'h2582; 5'd16: cp = 16'h250c; 5'd17: cp = 16'h2534;
            5'd18: cp = 16'h253c; 5'd19: cp = 16'h2524; 5'd20: cp = 16'h258e;
            5'd21: cp = 16'h258d; 5'd22: cp = 16'he0b6; 5'd23: cp = 16'he0b7;
            5'd24: cp = 16'he0b8; 5'd25: cp = 16'h2583; 5'd26: cp = 16'h2713;
            5'd27: cp = 16'h2596; 5'd28: cp = 16'h259d; 5'd29: cp = 16'h2518;
            5'd30: cp = 16'h2598; default: cp = 16'h259a;
         endcase
         if (iso_or_win) begin
            if (c == 8'ha3) cp = 16'h00af;
            else if (c == 8'ha4) cp = 16'h005f;
            else if (c == 8'hab) cp = 16'h007d;
            else if (c == 8'hb3) cp = 16'h007b;
         end
         if (!lower_font) begin
            if (c == 8'ha9) cp = 16'h25e4;
            else if (c == 8'hba) cp = 16'h259f;
         end
         return cp;
      end
      if (!lower_font) begin
         case (c[4:0])
            5'd0: cp = 16'h2500; 5'd1: cp = 16'h2660; 5'd2: cp = 16'he0c2;
            5'd3: cp = 16'he0c3; 5'd4: cp = 16'he0c4; 5'd5: cp = 16'he0c5;
            5'd6: cp = 16'he0c6; 5'd7: cp = 16'he0c7; 5'd8: cp = 16'he0c8;
            5'd9: cp = 16'h256e; 5'd10: cp = 16'h2570; 5'd11: cp = 16'h256f;
            5'd12: cp = 16'h2599; 5'd13: cp = 16'h2572; 5'd14: cp = 16'h2571;
            5'd15: cp = 16'h259b; 5'd16: cp = 16'h259c; 5'd17: cp = 16'h2219;
            5'd18: cp = 16'he0d2; 5'd19: cp = 16'h2665; 5'd20: cp = 16'he0d4;
            5'd21: cp = 16'h256d; 5'd22: cp = 16'h2573; 5'd23: cp = 16'h2218;
            5'd24: cp = 16'h2663; 5'd25: cp = 16'he0d9; 5'd26: cp = 16'h2666;
            5'd27: cp = 16'h253c; 5'd28: cp = 16'he0dc; 5'd29: cp = 16'h2502;
            5'd30: cp = 16'h03c0; default: cp = 16'h25e5;
         endcase
         return cp;
      end
      if (c == 8'hc0) return 16'h2500;
      if (c < 8'hdb) return {8'h00, c ^ 8'h80};
      if (c == 8'hdb) return 16'h253c;
      if (c == 8'hdc) return 16'he0dc;
      if (c == 8'hdd) return iso_or_win ? 16'h007c : 16'h2502;
      if (c == 8'hde) return 16'he1de;
      return 16'h25a7;
   endfunction

   // Clip a code point to the selected character set
   function automatic logic [15:0] clip_code_point(input logic [15:0] cp);
      case (shadow.target)
         SET_ASCII:   return (cp > 16'h7f) ? 16'h007f : cp;
         SET_LATIN1:  return (cp > 16'hff) ? 16'h007f : cp;
         SET_WIN1252: begin
            if (cp == 16'h2022 || cp == 16'h2219) return 16'h0095;
            if (cp > 16'hff || (cp >= 16'h80 && cp < 16'ha0)) return 16'h007f;
            return cp;
         end
         default:     return cp;
      endcase
   endfunction

   // Append the encoded form of one code point
   function automatic void encode_unit(input logic [15:0] cp, ref logic [7:0] seq[$]);
      case (shadow.encoding)
         ENC_BYTE:  seq.push_back((cp > 16'hff) ? 8'h7f : cp[7:0]);
         ENC_U16LE: begin
            seq.push_back(cp[7:0]);
            seq.push_back(cp[15:8]);
         end
         ENC_U16BE: begin
            seq.push_back(cp[15:8]);
            seq.push_back(cp[7:0]);
         end
         default: begin
            if (cp < 16'h80) begin
               seq.push_back(cp[7:0]);
            end else if (cp < 16'h800) begin
               seq.push_back(8'hc0 | cp[10:6]);
               seq.push_back(8'h80 | cp[5:0]);
            end else begin
               seq.push_back(8'he0 | cp[15:12]);
               seq.push_back(8'h80 | cp[11:6]);
               seq.push_back(8'h80 | cp[5:0]);
            end
         end
      endcase
   endfunction

   // Predict the bytes of one item and queue them
   task automatic predict_bytes(input logic [7:0] code, input logic start);
      logic [7:0] seq[$];
      out_item_t  e;
      if (start && shadow.bom) begin
         if (shadow.encoding == ENC_U16LE) begin
            seq.push_back(8'hff);
            seq.push_back(8'hfe);
         end else if (shadow.encoding == ENC_U16BE) begin
            seq.push_back(8'hfe);
            seq.push_back(8'hff);
         end
      end
      if (code == 8'h0d) begin
         case (shadow.newline)
            NL_CR:   encode_unit(16'h000d, seq);
            NL_LF:   encode_unit(16'h000a, seq);
            NL_LFCR: begin
               encode_unit(16'h000a, seq);
               encode_unit(16'h000d, seq);
            end
            default: begin
               encode_unit(16'h000d, seq);
               encode_unit(16'h000a, seq);
            end
         endcase
      end else begin
         encode_unit(clip_code_point(map_code_point(code)), seq);
      end
      foreach (seq[i]) begin
         e.byte_val = seq[i];
         e.last = (i == seq.size() - 1);
         expected_bytes.push_back(e);
      end
   endtask

   // Send one item, predicting at acceptance; valid stays up for a following item
   task automatic send_char(input logic [7:0] code, input logic start);
      req_valid <= 1'b1;
      req_petscii_byte <= code;
      req_text_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_bytes(code, start);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop the input valid between bursts
   task automatic idle_input;
      req_valid <= 1'b0;
   endtask

   // Send with random gaps in bursts
   task automatic send_bursty(input logic [7:0] code, input logic start);
      if ($urandom_range(0, 5) == 0) begin
         idle_input();
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      send_char(code, start);
   endtask

   // Wait until all expected bytes are out, then let the pipe settle
   task automatic drain;
      int guard;
      guard = 0;
      idle_input();
      while (expected_bytes.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
   endtask

   // Write one register and mirror it
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ENCODING: shadow.encoding = val[1:0];
         REG_TARGET:   shadow.target = val[1:0];
         REG_FONT:     shadow.font = val[0];
         REG_NEWLINE:  shadow.newline = val[1:0];
         REG_KEEP:     shadow.keep = val[2:0];
         REG_BOM:      shadow.bom = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [1:0] enc, input logic [1:0] tgt,
                             input logic fnt, input logic [1:0] nl,
                             input logic [2:0] kp, input logic bm);
      drain();
      write_reg(REG_ENCODING, {6'd0, enc});
      write_reg(REG_TARGET, {6'd0, tgt});
      write_reg(REG_FONT, {7'd0, fnt});
      write_reg(REG_NEWLINE, {6'd0, nl});
      write_reg(REG_KEEP, {5'd0, kp});
      write_reg(REG_BOM, {7'd0, bm});
      csr_valid <= 1'b0;
   endtask

   // Check each accepted output byte against the oldest prediction
   always @(posedge clock) begin
      out_item_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_seen++;
         if (expected_bytes.size() == 0) begin
            report_error($sformatf("unexpected byte %h", rsp_out_byte));
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_out_byte !== e.byte_val)
               report_error($sformatf("byte %h, want %h", rsp_out_byte, e.byte_val));
            if (rsp_last_of_run !== e.last)
               report_error($sformatf("last %b, want %b", rsp_last_of_run, e.last));
         end
      end
   end

   // Receiver stall pattern, plus long hold-off on request
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_off)
         rsp_stall <= 1'b1;
      else if (wrap_up)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Directed: field extremes, special codes under default setup
   task automatic test_directed_defaults;
      logic [7:0] codes[$];
      codes = '{8'h00, 8'h0d, 8'h41, 8'h5a, 8'h5c, 8'h5e, 8'h60, 8'h7f, 8'h80,
                8'h9f, 8'ha0, 8'hbf, 8'hc0, 8'hdf, 8'he0, 8'hfe, 8'hff};
      foreach (codes[i]) send_char(codes[i], i[0]);
   endtask

   // Directed: BOM, newline modes, keep bits and bullet mapping
   task automatic test_special_cases;
      set_config(ENC_U16LE, SET_UNICODE, 1'b0, NL_CR, 3'd7, 1'b1);
      send_char(8'h0d, 1'b1);
      send_char(8'h5c, 1'b0);
      set_config(ENC_U16BE, SET_UNICODE, 1'b1, NL_LFCR, 3'd0, 1'b1);
      send_char(8'h0d, 1'b1);
      send_char(8'hff, 1'b1);
      set_config(ENC_UTF8, SET_WIN1252, 1'b1, NL_LF, 3'd5, 1'b1);
      send_char(8'h71, 1'b1);
      send_char(8'h0d, 1'b0);
      send_char(8'h85, 1'b0);
      set_config(ENC_BYTE, SET_UNICODE, 1'b0, NL_CRLF, 3'd2, 1'b0);
      send_char(8'h5e, 1'b0);
      send_char(8'hff, 1'b0);
   endtask

   // Long receiver hold-off while the sender keeps going
   task automatic test_backpressure;
      set_config(ENC_UTF8, SET_UNICODE, 1'b0, NL_CRLF, 3'd0, 1'b0);
      fork
         begin
            hold_off = 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (12) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            idle_input();
         end
      join
   endtask

   // Random items across random configurations, extremes first
   task automatic test_random;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0)
            set_config(2'd3, 2'd3, 1'b1, 2'd3, 3'd7, 1'b1);
         else if (phase == 1)
            set_config(2'd0, 2'd0, 1'b0, 2'd0, 3'd0, 1'b0);
         else
            set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         repeat (20) send_bursty(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_petscii_byte = 8'h00;
      req_text_start = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_ENCODING;
      csr_data = 8'h00;
      hold_off = 1'b0;
      wrap_up = 1'b0;
      error_count = 0;
      items_sent = 0;
      bytes_seen = 0;
      shadow = '{encoding: ENC_BYTE, target: SET_ASCII, font: 1'b0,
                 newline: NL_CRLF, keep: 3'd0, bom: 1'b0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_defaults();
      test_special_cases();
      test_backpressure();
      test_random();
      wrap_up = 1'b1;
      drain();
      if (expected_bytes.size() != 0)
         report_error($sformatf("%0d bytes never arrived", expected_bytes.size()));
      $display("Covered %0d items, %0d output bytes, all encodings and target sets.",
               items_sent, bytes_seen);
      if (error_count == 0)
         $display("** petscii_to_unicode_transcoder_top: PASSED **");
      else
         $display("** petscii_to_unicode_transcoder_top: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("** petscii_to_unicode_transcoder_top: FAILED **");
      $finish;
   end

endmodule
